// File: rtl/fupd_pkg.sv
// Package for the form-urlencoded percent decoder.
// Holds the escape phase type, character codes and the hex digit decoder.
// Depends on nothing.
package fupd_pkg;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_HIGH = 2'd1,
		PH_LOW  = 2'd2
	} escape_phase_t;

	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_0       = 8'h30;
	localparam logic [7:0] CH_9       = 8'h39;
	localparam logic [7:0] CH_UA      = 8'h41;
	localparam logic [7:0] CH_UF      = 8'h46;
	localparam logic [7:0] CH_LA      = 8'h61;
	localparam logic [7:0] CH_LF      = 8'h66;
	localparam logic [7:0] HEX_TEN    = 8'd10;

	typedef struct packed {
		logic       ok;
		logic [3:0] value;
	} hex_digit_t;

	function automatic hex_digit_t hex_decode(input logic [7:0] c);
		hex_digit_t r;
		logic [7:0] d;
		r = '{ok: 1'b0, value: 4'd0};
		d = 8'd0;
		if (c >= CH_0 && c <= CH_9) begin
			d = c - CH_0;
			r.ok = 1'b1;
		end else if (c >= CH_UA && c <= CH_UF) begin
			d = c - CH_UA + HEX_TEN;
			r.ok = 1'b1;
		end else if (c >= CH_LA && c <= CH_LF) begin
			d = c - CH_LA + HEX_TEN;
			r.ok = 1'b1;
		end
		r.value = d[3:0];
		return r;
	endfunction

endpackage

// File: rtl/form_url_percent_decoder.sv
// Form-urlencoded percent decoder: one escaped byte in, at most one result out.
// Input register, short decode logic against the escape state, result register.
// Depends on fupd_pkg.
//
//   channel  handshake              payload
//   input    in_valid / in_stall    in_byte, is_last
//   output   out_valid / out_stall  out_byte, has_byte, end_of_text, decoded_count, truncated
//
// One byte is accepted per cycle unless in_stall; results pass input and result registers.
// The escape state updates as a byte leaves the input register, so the decode is one pass.
// Reset clears the escape state, byte count and both valid flags.
// A stalled output holds its result; the input stalls only when a waiting byte
// would produce a result and the result register cannot take it.
module form_url_percent_decoder
	import fupd_pkg::*;
#(
	parameter int unsigned MAX_TEXT_LEN = 65535
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  in_byte,
	input  logic        is_last,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_byte,
	output logic        has_byte,
	output logic        end_of_text,
	output logic [15:0] decoded_count,
	output logic        truncated
);

	localparam logic [15:0] COUNT_CAP =
		(MAX_TEXT_LEN < 32'd65535) ? 16'(MAX_TEXT_LEN) : 16'hFFFF;

	logic          valid_s1;
	logic [7:0]    byte_s1;
	logic          last_s1;

	escape_phase_t phase_q, phase_n;
	logic [3:0]    nibble_q, nibble_n;
	logic          stopped_q, stopped_n;
	logic [15:0]   count_q, count_n;

	logic          have;
	logic [7:0]    val;
	logic          produce;
	logic          advance;
	hex_digit_t    hd;

	logic          out_valid_q;
	logic [7:0]    out_byte_q;
	logic          has_byte_q;
	logic          end_q;
	logic [15:0]   count_out_q;
	logic          trunc_q;

	always_comb begin
		hd        = hex_decode(byte_s1);
		phase_n   = phase_q;
		nibble_n  = nibble_q;
		stopped_n = stopped_q;
		have      = 1'b0;
		val       = 8'd0;
		if (!stopped_q) begin
			unique case (phase_q)
				PH_HIGH: begin
					if (!hd.ok) begin
						stopped_n = 1'b1;
					end else begin
						nibble_n = hd.value;
						phase_n  = PH_LOW;
					end
				end
				PH_LOW: begin
					if (!hd.ok) begin
						stopped_n = 1'b1;
					end else begin
						val     = {nibble_q, hd.value};
						have    = 1'b1;
						phase_n = PH_IDLE;
					end
				end
				default: begin
					phase_n = PH_IDLE;
					if (byte_s1 == CH_PERCENT) begin
						phase_n = PH_HIGH;
					end else begin
						val  = (byte_s1 == CH_PLUS) ? CH_SPACE : byte_s1;
						have = 1'b1;
					end
				end
			endcase
			if (last_s1 && phase_n != PH_IDLE) begin
				stopped_n = 1'b1;
			end
		end
		count_n = (have && count_q < COUNT_CAP) ? count_q + 16'd1 : count_q;
	end

	assign produce  = have || last_s1;
	assign advance  = !produce || !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= in_byte;
			last_s1 <= is_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			nibble_q  <= 4'd0;
			stopped_q <= 1'b0;
			count_q   <= 16'd0;
		end else if (valid_s1 && advance) begin
			if (last_s1) begin
				phase_q   <= PH_IDLE;
				nibble_q  <= 4'd0;
				stopped_q <= 1'b0;
				count_q   <= 16'd0;
			end else begin
				phase_q   <= phase_n;
				nibble_q  <= nibble_n;
				stopped_q <= stopped_n;
				count_q   <= count_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (valid_s1 && advance && produce) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance && produce) begin
			out_byte_q  <= val;
			has_byte_q  <= have;
			end_q       <= last_s1;
			count_out_q <= count_n;
			trunc_q     <= last_s1 && stopped_n;
		end
	end

	assign out_valid     = out_valid_q;
	assign out_byte      = out_byte_q;
	assign has_byte      = has_byte_q;
	assign end_of_text   = end_q;
	assign decoded_count = count_out_q;
	assign truncated     = trunc_q;

`ifndef ASSERT_OFF
	a_trunc_only_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (!trunc_q || end_q))
		else $error("Truncation flagged on a result that does not end the text.");

	a_zero_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !has_byte_q) |-> (out_byte_q == 8'd0 && end_q))
		else $error("A result without a byte must be an end result with a zero byte.");

	a_state_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && advance && last_s1) |=>
			(phase_q == PH_IDLE && !stopped_q && count_q == 16'd0))
		else $error("Escape state not cleared after the last byte of a text.");

	a_count_capped: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= COUNT_CAP)
		else $error("Decoded byte count exceeds its cap.");

	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid_q && out_stall))
		else $error("Input stalled without a blocked result.");
`endif

endmodule
